// File: design/sha256_pkg.sv
// sha256_pkg: shared types, constants and message schedule functions for the sha-256 engine
// no dependencies
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // word handed from the byte collector to the compression core
    typedef struct packed {
        logic [31:0] word;
        logic        blk_last;   // sixteenth word of a block
        logic        msg_last;   // last word of the final block of the message
    } t_word_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_core_state;

    typedef enum logic [1:0] {
        PD_NONE,
        PD_FILL,
        PD_LEN
    } t_pad_state;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [63:0] BLOCK_BITS = 64'd512;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

endpackage

// File: design/sha256_front.sv
// sha256_front: packs message bytes into big-endian words, adds padding and length
// depends on sha256_pkg
module sha256_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  sha256_pkg::t_in_item  i_item,
    output logic                  o_wvalid,
    input  logic                  i_wready,
    output sha256_pkg::t_word_item o_witem
);
    logic [23:0]            r_acc, n_acc;
    logic [5:0]             r_pos, n_pos;      // byte position within the block
    logic [63:0]            r_bits, n_bits;    // bits of the message so far
    sha256_pkg::t_pad_state r_pad, n_pad;
    logic                   r_two, n_two;      // padding runs over two blocks
    logic                   r_wv, n_wv;
    sha256_pkg::t_word_item r_w, n_w;

    logic        take;
    logic [31:0] word_b;

    assign o_full   = (r_pad != sha256_pkg::PD_NONE) || r_wv;
    assign take     = i_push && !o_full;
    assign o_wvalid = r_wv;
    assign o_witem  = r_w;

    always_comb begin
        n_acc  = r_acc;
        n_pos  = r_pos;
        n_bits = r_bits;
        n_pad  = r_pad;
        n_two  = r_two;
        n_wv   = r_wv && !i_wready;
        n_w    = r_w;
        word_b = 32'd0;
        if (take) begin
            if (i_item.byte_valid) begin
                n_bits = r_bits + 64'd8;
                if (r_pos[1:0] == 2'd3) begin
                    n_wv = 1'b1;
                    n_w.word = {r_acc, i_item.data_byte};
                    n_w.blk_last = (r_pos == 6'd63);
                    n_w.msg_last = 1'b0;
                end else begin
                    n_acc = {r_acc[15:0], i_item.data_byte};
                end
                n_pos = r_pos + 6'd1;
            end
            if (i_item.end_of_message) begin
                n_pad = sha256_pkg::PD_FILL;
                n_two = ((i_item.byte_valid ? r_pos + 6'd1 : r_pos) >= 6'd56);
                if (i_item.byte_valid && r_pos[1:0] != 2'd3)
                    n_acc = {r_acc[15:0], i_item.data_byte};
            end
        end else if (r_pad != sha256_pkg::PD_NONE && !r_wv) begin
            // emit a padding word whenever the output word register is empty
            if (r_pad == sha256_pkg::PD_FILL && !(r_two == 1'b0 && r_pos == 6'd56)) begin
                case (r_pos[1:0])
                    2'd0: word_b = {sha256_pkg::PAD_BYTE, 24'd0};
                    2'd1: word_b = {r_acc[7:0], sha256_pkg::PAD_BYTE, 16'd0};
                    2'd2: word_b = {r_acc[15:0], sha256_pkg::PAD_BYTE, 8'd0};
                    default: word_b = {r_acc, sha256_pkg::PAD_BYTE};
                endcase
                n_wv = 1'b1;
                n_w.word = word_b;
                n_w.blk_last = (r_pos[5:2] == 4'd15);
                n_w.msg_last = 1'b0;
                n_acc = 24'd0;
                n_pos = {r_pos[5:2] + 4'd1, 2'b00};
                n_pad = sha256_pkg::PD_LEN;
                if (r_pos[5:2] == 4'd15) n_two = 1'b0;
            end else begin
                // zero words up to the length, then the two length words
                n_wv = 1'b1;
                n_w.blk_last = (r_pos == 6'd60);
                n_w.msg_last = (r_pos == 6'd60) && !r_two;
                if (!r_two && r_pos == 6'd56) n_w.word = r_bits[63:32];
                else if (!r_two && r_pos == 6'd60) n_w.word = r_bits[31:0];
                else n_w.word = 32'd0;
                n_pos = r_pos + 6'd4;
                if (r_pos == 6'd60) n_two = 1'b0;
                n_pad = sha256_pkg::PD_LEN;
                if (!r_two && r_pos == 6'd60) begin
                    n_pad  = sha256_pkg::PD_NONE;
                    n_bits = 64'd0;
                    n_pos  = 6'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_bits <= '0;
            r_pad <= sha256_pkg::PD_NONE;
            r_two <= 1'b0;
            r_wv <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_bits <= n_bits;
            r_pad <= n_pad;
            r_two <= n_two;
            r_wv <= n_wv;
        end
        r_acc <= n_acc;
        r_w <= n_w;
    end

    a_len_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wv && r_w.msg_last |-> r_w.blk_last) else $error("final word not block end");
    a_full_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad != sha256_pkg::PD_NONE |-> o_full) else $error("input open while padding");
    a_pos_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad == sha256_pkg::PD_LEN |-> r_pos[1:0] == 2'd0) else $error("unaligned pad");
endmodule

// File: design/sha256_wfifo.sv
// sha256_wfifo: short word queue between the byte packer and the compression core
// depends on sha256_pkg
module sha256_wfifo #(
    parameter int Depth = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wvalid,
    output logic                   o_wready,
    input  sha256_pkg::t_word_item i_witem,
    output logic                   o_rvalid,
    input  logic                   i_rready,
    output sha256_pkg::t_word_item o_ritem
);
    localparam int Aw = $clog2(Depth);
    sha256_pkg::t_word_item r_mem [Depth];
    logic [Aw-1:0] r_wp, r_rp;
    logic [Aw:0]   r_cnt;
    logic wr, rd;

    assign o_wready = (r_cnt != Depth[Aw:0]);
    assign o_rvalid = (r_cnt != '0);
    assign wr = i_wvalid && o_wready;
    assign rd = o_rvalid && i_rready;
    assign o_ritem = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == Aw'(Depth - 1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == Aw'(Depth - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (Aw+1)'(wr) - (Aw+1)'(rd);
        end
        if (wr) r_mem[r_wp] <= i_witem;
    end
endmodule

// File: design/sha256_core.sv
// sha256_core: message schedule, 64-round compression and digest readout
// depends on sha256_pkg
module sha256_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wvalid,
    output logic                   o_wready,
    input  sha256_pkg::t_word_item i_witem,
    output logic                   o_empty,
    input  logic                   i_pop,
    output sha256_pkg::t_out_item  o_item
);
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [6:0]  r_rnd;
    logic        r_last;
    logic [2:0]  r_oi;
    sha256_pkg::t_core_state r_st, n_st;

    logic [31:0] wt, t1, t2, s1, s0, ch, mj;
    logic        step;

    // round 0..15 takes words from the queue, later rounds expand
    always_comb begin
        wt = (r_rnd < 7'd16) ? i_witem.word
           : r_w[0] + sha256_pkg::sig0(r_w[1]) + r_w[9] + sha256_pkg::sig1(r_w[14]);
        s1 = sha256_pkg::ror(r_v[4], 6) ^ sha256_pkg::ror(r_v[4], 11)
           ^ sha256_pkg::ror(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        s0 = sha256_pkg::ror(r_v[0], 2) ^ sha256_pkg::ror(r_v[0], 13)
           ^ sha256_pkg::ror(r_v[0], 22);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1 = r_v[7] + s1 + ch + sha256_pkg::ROUND_K[r_rnd[5:0]] + wt;
        t2 = s0 + mj;
    end

    assign step     = (r_st == sha256_pkg::ST_ROUND) && (r_rnd >= 7'd16 || i_wvalid);
    assign o_wready = (r_st == sha256_pkg::ST_ROUND) && (r_rnd < 7'd16);
    assign o_empty  = (r_st != sha256_pkg::ST_OUT);
    assign o_item.digest_word = r_h[r_oi];
    assign o_item.word_index  = r_oi;
    assign o_item.last_word   = (r_oi == 3'd7);

    always_comb begin
        n_st = r_st;
        case (r_st)
            sha256_pkg::ST_IDLE:  n_st = sha256_pkg::ST_ROUND;
            sha256_pkg::ST_ROUND: if (step && r_rnd == 7'd63) n_st = sha256_pkg::ST_ADD;
            sha256_pkg::ST_ADD:   n_st = r_last ? sha256_pkg::ST_OUT : sha256_pkg::ST_ROUND;
            sha256_pkg::ST_OUT:   if (i_pop && r_oi == 3'd7) n_st = sha256_pkg::ST_IDLE;
            default:              n_st = sha256_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= sha256_pkg::ST_IDLE;
            r_rnd <= '0;
            r_oi <= '0;
            r_last <= 1'b0;
            r_h <= sha256_pkg::INIT_H;
            r_v <= sha256_pkg::INIT_H;
        end else begin
            r_st <= n_st;
            case (r_st)
                sha256_pkg::ST_IDLE: begin
                    r_h <= sha256_pkg::INIT_H;
                    r_v <= sha256_pkg::INIT_H;
                    r_rnd <= '0;
                    r_oi <= '0;
                    r_last <= 1'b0;
                end
                sha256_pkg::ST_ROUND: if (step) begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= wt;
                    r_v[0] <= t1 + t2;
                    r_v[1] <= r_v[0];
                    r_v[2] <= r_v[1];
                    r_v[3] <= r_v[2];
                    r_v[4] <= r_v[3] + t1;
                    r_v[5] <= r_v[4];
                    r_v[6] <= r_v[5];
                    r_v[7] <= r_v[6];
                    r_rnd <= r_rnd + 7'd1;
                    if (r_rnd == 7'd15) r_last <= i_witem.msg_last;
                end
                sha256_pkg::ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                        r_v[i] <= r_h[i] + r_v[i];
                    end
                    r_rnd <= '0;
                end
                sha256_pkg::ST_OUT: if (i_pop) r_oi <= r_oi + 3'd1;
                default: ;
            endcase
        end
    end

    a_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == sha256_pkg::ST_ADD |-> $past(r_rnd) == 7'd63) else $error("short block");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wready && i_wvalid && i_witem.blk_last |-> r_rnd == 7'd15) else $error("misaligned word");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> !o_wready) else $error("input during output");
endmodule

// File: design/sha256_message_digest_top.sv
// sha256_message_digest_top: streaming sha-256, bytes in, eight digest words out
// depends on sha256_pkg, sha256_front, sha256_wfifo, sha256_core
// each block: 64 rounds, then an add step into the hash state
// flow: the core takes words only in rounds 0 to 15, so packing stalls in later rounds once the queue fills
// end of message: pad words up to block end, two blocks when 8 bytes or fewer are free
// reset: synchronous active low, restores the initial hash values, queues emptied
module sha256_message_digest_top #(
    parameter int FifoDepth = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  sha256_pkg::t_in_item  i_item,
    output logic                  empty,
    input  logic                  pop,
    output sha256_pkg::t_out_item o_item
);
    // front to queue and queue to core
    logic                   fv, fr, qv, qr;
    sha256_pkg::t_word_item fw, qw;

    // byte packer and padding
    sha256_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(i_item), .o_wvalid(fv), .i_wready(fr), .o_witem(fw));

    // word transfer queue decouples packing from rounds
    sha256_wfifo #(.Depth(FifoDepth)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wvalid(fv), .o_wready(fr),
        .i_witem(fw), .o_rvalid(qv), .i_rready(qr), .o_ritem(qw));

    // compression and digest readout
    sha256_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wvalid(qv), .o_wready(qr),
        .i_witem(qw), .o_empty(empty), .i_pop(pop), .o_item(o_item));
endmodule

// File: sim/sha256_digest_checker.sv
// sha256_digest_checker: watches the byte and digest queues of the sha-256 engine,
// predicts each digest with its own compression and compares word by word; uses sha256_pkg
module sha256_digest_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_full,
    input  sha256_pkg::t_in_item  i_item,
    input  logic                  i_empty,
    input  logic                  i_pop,
    input  sha256_pkg::t_out_item i_result,
    output int                    o_fail_count,
    output int                    o_words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    logic [7:0]            blk [64];
    int                    fill;
    logic [63:0]           bits_done;
    logic [31:0]           hash_state [8];
    sha256_pkg::t_out_item digest_q [$];
    int                    fails = 0;

    assign o_fail_count    = fails;
    assign o_words_pending = digest_q.size();

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                                    hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
        for (int i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + KTAB[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    task automatic restart();
        fill = 0;
        bits_done = '0;
        for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
    endtask

    // one accepted byte or end marker
    task automatic take_item(sha256_pkg::t_in_item it);
        logic [63:0]           len;
        sha256_pkg::t_out_item word;
        if (it.byte_valid) begin
            blk[fill] = it.data_byte;
            fill++;
            if (fill == 64) begin
                compress();
                bits_done += 64'd512;
                fill = 0;
            end
        end
        if (!it.end_of_message) return;
        len = bits_done + 64'(fill) * 8;
        blk[fill] = 8'h80;
        for (int i = fill + 1; i < 64; i++) blk[i] = 8'h00;
        // no room for the length: spill into a second block
        if (fill >= 56) begin
            compress();
            for (int i = 0; i < 64; i++) blk[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++) blk[56+i] = len[63-8*i -: 8];
        compress();
        for (int i = 0; i < 8; i++) begin
            word.digest_word = hash_state[i];
            word.word_index  = 3'(i);
            word.last_word   = (i == 7);
            digest_q.insert(digest_q.size(), word);
        end
        restart();
    endtask

    always @(posedge i_clk) begin
        sha256_pkg::t_out_item want;
        if (!i_rst_n) begin
            restart();
            digest_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (digest_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected digest word %h idx %0d last %0b",
                                 i_result.digest_word, i_result.word_index, i_result.last_word);
                end else begin
                    want = digest_q.pop_front();
                    if (want !== i_result) begin
                        fails++;
                        if (fails <= 10)
                            $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                                     want.digest_word, want.word_index, want.last_word,
                                     i_result.digest_word, i_result.word_index,
                                     i_result.last_word);
                    end
                end
            end
            if (i_push && !i_full) take_item(i_item);
        end
    end
endmodule

// File: sim/sha256_message_digest_top_tb.sv
// sha256_message_digest_top_tb: stimulus and verdict for the streaming sha-256 engine
// depends on sha256_pkg, sha256_message_digest_top and sha256_digest_checker
module sha256_message_digest_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  pop = 1'b0;
    logic                  full, empty;
    sha256_pkg::t_in_item  i_item = '0;
    sha256_pkg::t_out_item o_item;
    int                    fail_count, words_pending;

    // idle percentages for sender and receiver, changed per phase
    int        send_idle = 0;
    int        take_stall = 0;
    int        quiet_cycles = 0;
    int        items_sent = 0;

    always #6 i_clk = ~i_clk;

    sha256_message_digest_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_item (i_item),
        .empty  (empty),
        .pop    (pop),
        .o_item (o_item)
    );

    sha256_digest_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_item         (i_item),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_result       (o_item),
        .o_fail_count   (fail_count),
        .o_words_pending(words_pending)
    );

    // receiver: pop at random, held low for a share of cycles per phase
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= take_stall);
        end
    end

    // watchdog: cycles in which nothing transfers on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL sha256_message_digest_top");
                $finish;
            end
        end
    end

    // one transfer into the engine, with random idle gaps before it
    task automatic send(logic [7:0] b, logic v, logic eom);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= '{data_byte: b, byte_valid: v, end_of_message: eom};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++) begin
            // occasional idle item inside the message
            if ($urandom_range(19) == 0) send(8'($urandom), 1'b0, 1'b0);
            send(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(1));
            if ((i == len - 1) && i_item.end_of_message) return;
        end
        send(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message, idle item, extreme bytes, length around the pad split
        send(8'hff, 1'b0, 1'b1);
        send(8'h00, 1'b0, 1'b0);
        send(8'h00, 1'b1, 1'b0);
        send(8'hff, 1'b1, 1'b1);
        send(8'h55, 1'b1, 1'b0);
        send(8'haa, 1'b0, 1'b1);
        drain();   // sender waits for every digest word
        for (int i = 0; i < 56; i++) send(8'(i), 1'b1, i == 55);
        for (int i = 0; i < 55; i++) send(8'hff - 8'(i), 1'b1, i == 54);
        drain();

        // random messages across idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0;  take_stall = 0;  end
                1: begin send_idle = 65; take_stall = 0;  end
                2: begin send_idle = 0;  take_stall = 65; end
                default: begin send_idle = 26; take_stall = 26; end
            endcase
            while (items_sent < 110 + 40 * (ph + 1)) begin
                case ($urandom_range(5))
                    0: send_message($urandom_range(1, 3));
                    1: send_message($urandom_range(54, 66));
                    2: send_message(64);
                    3: send_message($urandom_range(119, 130));
                    default: send_message($urandom_range(4, 40));
                endcase
            end
            drain();
        end

        send_idle = 0;
        take_stall = 0;
        drain();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && words_pending == 0) begin
            $display("PASS sha256_message_digest_top");
        end else begin
            $display("FAIL sha256_message_digest_top");
        end
        $finish;
    end
endmodule
